[rtl/mbd_pkg.sv]
// mbd_pkg: shared constants and types for the multi-button debouncer
// no dependencies
`default_nettype none

package mbd_pkg;

    localparam int CHANNELS    = 5;
    localparam int REMOTE_BITS = 4;
    localparam int CNT_W       = 8;
    localparam int MASK_W      = CHANNELS;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;

    // channel positions within the pin word
    localparam int IDX_FOLLOW = 0;
    localparam int IDX_STOP   = 1;
    localparam int IDX_TOUCH0 = 2;
    localparam int IDX_TOUCH1 = 3;
    localparam int IDX_REMOTE = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MASK  = 2'd2;

    localparam logic [CNT_W-1:0]  RST_THRESHOLD = 8'd5;
    localparam logic [CNT_W-1:0]  RST_DIVIDE    = 8'd3;
    localparam logic [MASK_W-1:0] RST_LOW_MASK  = 5'd15;

    // stream payload widths
    localparam int IN_FIELDS_W  = CHANNELS + REMOTE_BITS;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CHANNELS + 1 + 1 + 2 + REMOTE_BITS + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // per-channel status towards the top level
    typedef struct packed {
        logic state_next;
        logic press;
    } t_chan_status;

endpackage

`default_nettype wire

[rtl/mbd_prescaler.sv]
// mbd_prescaler: counts advancing ticks and flags every n-th one
// depends on mbd_pkg
`default_nettype none

module mbd_prescaler (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_step,
    input  wire [mbd_pkg::CNT_W-1:0] i_divide,
    output logic                     o_act
);
    import mbd_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] count_inc;
    logic             hit;

    assign count_inc = r_count + CNT_W'(1);
    assign hit       = (count_inc >= i_divide);
    assign o_act     = i_step && hit;

    always_comb begin
        n_count = r_count;
        if (i_step) begin
            n_count = hit ? '0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

[rtl/mbd_channel.sv]
// mbd_channel: debounce cell for one pin, state bit and hold counter
// depends on mbd_pkg
`default_nettype none

module mbd_channel (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_act,
    input  wire                       i_sample,
    input  wire [mbd_pkg::CNT_W-1:0]  i_threshold,
    output mbd_pkg::t_chan_status     o_status
);
    import mbd_pkg::*;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_hold;
    logic [CNT_W-1:0] n_hold;
    logic             flip;

    always_comb begin
        n_state = r_state;
        n_hold  = r_hold;
        flip    = 1'b0;
        if (i_act) begin
            if (i_sample != r_state) begin
                if (r_hold >= i_threshold) begin
                    flip    = 1'b1;
                    n_state = ~r_state;
                    n_hold  = '0;
                end else begin
                    n_hold = r_hold + CNT_W'(1);
                end
            end else begin
                n_hold = '0;
            end
        end
    end

    assign o_status.state_next = n_state;
    assign o_status.press      = flip && i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 1'b0;
            r_hold  <= '0;
        end else begin
            r_state <= n_state;
            r_hold  <= n_hold;
        end
    end

endmodule

`default_nettype wire

[rtl/multi_button_debouncer_unit.sv]
// multi_button_debouncer_unit: top level of the five-channel pin debouncer
// depends on mbd_pkg, mbd_prescaler, mbd_channel
//
// usage
// - input stream: one transaction per system tick; tuser carries the tick
//   advanced flag, tdata the raw pin levels and the remote data pins
// - output stream: exactly one transaction per input transaction, in order,
//   with the debounced states, derived flags, latched remote code and a
//   one-transaction fresh pulse on each debounced remote press
// - config port: write enable, index and data; written while idle
// - output: each result is registered in the output register from its accepted input transaction
// - throughput: one transaction per cycle while the output is not stalled;
//   state update and result are computed in a single pass between the state
//   registers and the output register
// - stall: a result held for the receiver still lets a new transaction in
//   on the cycle the receiver takes it; otherwise s_axis_tready drops
// - reset: synchronous active low; configuration returns to threshold 5,
//   divide 3, active-low mask 15; all channels released, counters and
//   remote code cleared, output stream empty
`default_nettype none

module multi_button_debouncer_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // config write port
    input  wire                              i_cfg_we,
    input  wire [mbd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [mbd_pkg::CFG_W-1:0]         i_cfg_data,
    // input stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [4:0] pin_levels, [8:5] remote_data, rest zero
    input  wire [mbd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] tick_advanced
    input  wire                              s_axis_tuser,
    // output stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [4:0] debounced_pressed, [5] follow_line_flag, [6] stop_flag,
    // [8:7] touch_flags, [12:9] remote_code, [13] code_strobe, rest zero
    output logic [mbd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import mbd_pkg::*;

    logic [CNT_W-1:0]       r_threshold;
    logic [CNT_W-1:0]       r_divide;
    logic [MASK_W-1:0]      r_low_mask;

    logic                   accept;
    logic                   act;
    logic [CHANNELS-1:0]    pins;
    logic [REMOTE_BITS-1:0] rdata;
    logic [CHANNELS-1:0]    samples;
    t_chan_status           status [CHANNELS];
    logic [CHANNELS-1:0]    state_next;

    logic [REMOTE_BITS-1:0] r_code;
    logic [REMOTE_BITS-1:0] n_code;
    logic                   fresh;

    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic [OUT_FIELDS_W-1:0] out_fields;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_divide    <= RST_DIVIDE;
            r_low_mask  <= RST_LOW_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_DIVIDE:    r_divide    <= i_cfg_data;
                CFG_LOW_MASK:  r_low_mask  <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pins          = s_axis_tdata[CHANNELS-1:0];
    assign rdata         = s_axis_tdata[CHANNELS +: REMOTE_BITS];
    assign samples       = pins ^ r_low_mask;

    mbd_prescaler u_prescaler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept && s_axis_tuser),
        .i_divide (r_divide),
        .o_act    (act)
    );

    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        mbd_channel u_channel (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_act       (act),
            .i_sample    (samples[g]),
            .i_threshold (r_threshold),
            .o_status    (status[g])
        );
        assign state_next[g] = status[g].state_next;
    end

    // remote code latch on a debounced press
    assign fresh  = status[IDX_REMOTE].press;
    assign n_code = fresh ? rdata : r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
        end else begin
            r_code <= n_code;
        end
    end

    assign out_fields = {fresh,
                         n_code,
                         state_next[IDX_TOUCH0],
                         state_next[IDX_TOUCH1],
                         state_next[IDX_STOP],
                         ~state_next[IDX_FOLLOW],
                         state_next};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= accept || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= OUT_DATA_W'(out_fields);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a fresh pulse only comes with the remote channel pressed
    a_fresh_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[OUT_FIELDS_W-1]) |-> m_axis_tdata[IDX_REMOTE])
        else $error("remote fresh without remote pressed");

    // follow-line flag is the inverted follow-line state
    a_follow_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CHANNELS] != m_axis_tdata[IDX_FOLLOW]))
        else $error("follow-line flag not inverted state");

    // the latched code only moves with a fresh pulse
    a_code_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!fresh && accept) |=> $stable(r_code))
        else $error("remote code changed without a press");

    // no result without an accepted transaction
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && !(r_out_valid && !m_axis_tready)) |=> !m_axis_tvalid)
        else $error("result without a transaction");

endmodule

`default_nettype wire
